[rtl/hrkd_pkg.sv]
// ----------------------------------------------------------------------------
// hrkd_pkg
// Shared constants, types and controller/datapath links for the HID boot
// keyboard report differencer.
// ----------------------------------------------------------------------------
package hrkd_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int INPUT_SLOTS = 6;
    localparam int KEY_W       = 8;
    localparam int MOD_W       = 8;
    localparam int EVT_N       = 2 * KEY_SLOTS;
    localparam int IDX_W       = $clog2(EVT_N);
    localparam int SLOT_W      = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int CNT_W       = $clog2(KEY_SLOTS + 1);
    localparam int COPY_SLOTS  = (KEY_SLOTS < INPUT_SLOTS) ? KEY_SLOTS : INPUT_SLOTS;

    localparam logic [KEY_W-1:0] CAPS_CODE_RESET = 8'd57;
    localparam logic [KEY_W-1:0] EMPTY_KEY       = 8'h00;
    localparam logic [MOD_W-1:0] MOD_CTRL        = 8'h01;
    localparam logic [MOD_W-1:0] MOD_SHIFT       = 8'h02;
    localparam logic [MOD_W-1:0] MOD_ALT         = 8'h04;

    localparam logic OP_REPORT  = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;
    localparam logic EV_RELEASE = 1'b0;
    localparam logic EV_PRESS   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic [MOD_W-1:0]                    modifier_bits;
        logic [INPUT_SLOTS-1:0][KEY_W-1:0]   key_slot;
    } t_report;

    typedef struct packed {
        logic             event_kind;
        logic [KEY_W-1:0] key_code;
        logic             ctrl_held;
        logic             shift_held;
        logic             alt_held;
        logic             capslock_on;
        logic             last_event;
    } t_event;

    typedef struct packed {
        logic clear;
        logic load;
        logic build;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic req_clear;
        logic hit;
        logic slot_free;
        logic scan_end;
    } t_status;

endpackage

[rtl/hrkd_if.sv]
// ----------------------------------------------------------------------------
// hrkd_if
// Valid/ready channel interfaces: report requests, events, config writes.
// ----------------------------------------------------------------------------
interface hrkd_req_if import hrkd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [MOD_W-1:0] modifier_bits;
    logic [KEY_W-1:0] key_slot_0;
    logic [KEY_W-1:0] key_slot_1;
    logic [KEY_W-1:0] key_slot_2;
    logic [KEY_W-1:0] key_slot_3;
    logic [KEY_W-1:0] key_slot_4;
    logic [KEY_W-1:0] key_slot_5;

    modport source (
        output valid, operation, modifier_bits,
        output key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
        input  ready
    );
    modport sink (
        input  valid, operation, modifier_bits,
        input  key_slot_0, key_slot_1, key_slot_2, key_slot_3, key_slot_4, key_slot_5,
        output ready
    );
endinterface

interface hrkd_evt_if import hrkd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             event_kind;
    logic [KEY_W-1:0] key_code;
    logic             ctrl_held;
    logic             shift_held;
    logic             alt_held;
    logic             capslock_on;
    logic             last_event;

    modport source (
        output valid, event_kind, key_code, ctrl_held, shift_held, alt_held,
        output capslock_on, last_event,
        input  ready
    );
    modport sink (
        input  valid, event_kind, key_code, ctrl_held, shift_held, alt_held,
        input  capslock_on, last_event,
        output ready
    );
endinterface

interface hrkd_cfg_if import hrkd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/hrkd_ctrl.sv]
// ----------------------------------------------------------------------------
// hrkd_ctrl
// Sequencer: takes a request, builds the change masks, walks the release and
// press slots one per cycle unless an event stalls, then commits the new list.
// ----------------------------------------------------------------------------
module hrkd_ctrl import hrkd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_status.req_clear) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.build = 1'b1;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                if (!i_status.hit || i_status.slot_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.scan_end) begin
                        n_state = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/hrkd_datapath.sv]
// ----------------------------------------------------------------------------
// hrkd_datapath
// Held key list, capslock state, latched report, change masks, slot index
// and the event output register.
// ----------------------------------------------------------------------------
module hrkd_datapath import hrkd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_status          o_status,
    input  logic             i_req_op,
    input  t_report          i_report,
    input  logic             i_cfg_valid,
    input  logic [KEY_W-1:0] i_cfg_data,
    output logic             o_evt_valid,
    input  logic             i_evt_ready,
    output t_event           o_evt
);

    logic [KEY_W-1:0]                  r_caps_code;
    logic [KEY_SLOTS-1:0][KEY_W-1:0]   r_held;
    logic [CNT_W-1:0]                  r_held_cnt;
    logic                              r_caps;
    logic [MOD_W-1:0]                  r_mods;
    logic [KEY_SLOTS-1:0][KEY_W-1:0]   r_keys;
    logic [CNT_W-1:0]                  r_cnt;
    logic [EVT_N-1:0]                  r_mask;
    logic [IDX_W-1:0]                  r_idx;
    logic                              r_evt_valid;
    t_event                            r_evt;

    logic [KEY_SLOTS-1:0][KEY_W-1:0]   n_keys;
    logic [CNT_W-1:0]                  n_cnt;
    logic [KEY_SLOTS-1:0]              w_rel;
    logic [KEY_SLOTS-1:0]              w_prs;
    logic                              w_is_press;
    logic [IDX_W-1:0]                  w_off;
    logic [SLOT_W-1:0]                 w_slot;
    logic [KEY_W-1:0]                  w_key;
    logic                              w_toggle;
    logic                              w_hit;
    logic [EVT_N-1:0]                  w_rest;

    // New key list from the request, slots past the input read as empty
    always_comb begin
        n_keys = '0;
        for (int i = 0; i < COPY_SLOTS; i++) begin
            n_keys[i] = i_report.key_slot[i];
        end
        n_cnt = CNT_W'(KEY_SLOTS);
        for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
            if (n_keys[i] == EMPTY_KEY) begin
                n_cnt = CNT_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            w_rel[i] = (CNT_W'(i) < r_held_cnt);
            w_prs[i] = (CNT_W'(i) < r_cnt);
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if ((CNT_W'(j) < r_cnt) && (r_keys[j] == r_held[i])) begin
                    w_rel[i] = 1'b0;
                end
                if ((CNT_W'(j) < r_held_cnt) && (r_held[j] == r_keys[i])) begin
                    w_prs[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        w_is_press = (r_idx >= IDX_W'(KEY_SLOTS));
        w_off      = w_is_press ? (r_idx - IDX_W'(KEY_SLOTS)) : r_idx;
        w_slot     = w_off[SLOT_W-1:0];
        w_key      = w_is_press ? r_keys[w_slot] : r_held[w_slot];
        w_toggle   = w_is_press && (w_key == r_caps_code);
        w_hit      = r_mask[r_idx];
        w_rest     = r_mask & ~(EVT_N'(1) << r_idx);
    end

    always_comb begin
        o_status.req_clear = (i_req_op == OP_CLEAR);
        o_status.hit       = w_hit;
        o_status.slot_free = !r_evt_valid || i_evt_ready;
        o_status.scan_end  = (r_idx == IDX_W'(EVT_N - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caps_code <= CAPS_CODE_RESET;
            r_held      <= '0;
            r_held_cnt  <= '0;
            r_caps      <= 1'b0;
            r_mask      <= '0;
            r_idx       <= '0;
            r_evt_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_caps_code <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_held     <= '0;
                r_held_cnt <= '0;
                r_caps     <= 1'b0;
            end
            if (i_cmd.build) begin
                r_mask <= {w_prs, w_rel};
                r_idx  <= '0;
            end
            if (i_cmd.step) begin
                r_mask[r_idx] <= 1'b0;
                if (r_idx != IDX_W'(EVT_N - 1)) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (w_hit) begin
                    r_caps <= r_caps ^ w_toggle;
                end
            end
            if (i_cmd.commit) begin
                r_held     <= r_keys;
                r_held_cnt <= r_cnt;
            end
            if (i_cmd.step && w_hit) begin
                r_evt_valid <= 1'b1;
            end else if (i_evt_ready) begin
                r_evt_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mods <= i_report.modifier_bits;
            r_keys <= n_keys;
            r_cnt  <= n_cnt;
        end
        if (i_cmd.step && w_hit) begin
            r_evt.event_kind  <= w_is_press ? EV_PRESS : EV_RELEASE;
            r_evt.key_code    <= w_key;
            r_evt.ctrl_held   <= |(r_mods & MOD_CTRL);
            r_evt.shift_held  <= |(r_mods & MOD_SHIFT);
            r_evt.alt_held    <= |(r_mods & MOD_ALT);
            r_evt.capslock_on <= r_caps ^ w_toggle;
            r_evt.last_event  <= (w_rest == '0);
        end
    end

    assign o_evt_valid = r_evt_valid;
    assign o_evt       = r_evt;

endmodule

[rtl/hid_report_key_event_diff_core.sv]
// ----------------------------------------------------------------------------
// hid_report_key_event_diff_core
// Turns USB HID boot keyboard reports into key release and press events.
// ----------------------------------------------------------------------------
// Channels: i_req takes one request per report (operation, modifier byte,
// six key slots); o_evt gives one event per changed key; i_cfg writes the
// capslock key code and is always ready. All are valid/ready handshakes.
// A report request steps through release slots then press slots, one slot
// per clock while no event is stalled by o_evt.ready, passing through the
// load, scan and commit states before the next request can be taken.
// At best the first event comes from the first slot of the scan, after load and mask build.
// A clear request empties the held key list, turns capslock off and gives no events.
// Events leave through one output register; while the receiver holds ready
// low the slot walk waits on the next changed slot and nothing is lost.
// The last event of a report carries last_event high.
// Reset (i_rst_n low, synchronous) empties the held key list, turns the
// capslock flag off, sets the capslock code to 57 and drops any event.
// ----------------------------------------------------------------------------
module hid_report_key_event_diff_core import hrkd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrkd_req_if.sink  i_req,
    hrkd_cfg_if.sink  i_cfg,
    hrkd_evt_if.source o_evt
);

    t_cmd    w_cmd;
    t_status w_status;
    t_report w_report;
    t_event  w_evt;
    logic    w_evt_valid;
    logic    w_req_ready;

    always_comb begin
        w_report.modifier_bits = i_req.modifier_bits;
        w_report.key_slot[0]   = i_req.key_slot_0;
        w_report.key_slot[1]   = i_req.key_slot_1;
        w_report.key_slot[2]   = i_req.key_slot_2;
        w_report.key_slot[3]   = i_req.key_slot_3;
        w_report.key_slot[4]   = i_req.key_slot_4;
        w_report.key_slot[5]   = i_req.key_slot_5;
    end

    hrkd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    hrkd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_req_op    (i_req.operation),
        .i_report    (w_report),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_evt_valid (w_evt_valid),
        .i_evt_ready (o_evt.ready),
        .o_evt       (w_evt)
    );

    assign i_req.ready       = w_req_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_evt.valid       = w_evt_valid;
    assign o_evt.event_kind  = w_evt.event_kind;
    assign o_evt.key_code    = w_evt.key_code;
    assign o_evt.ctrl_held   = w_evt.ctrl_held;
    assign o_evt.shift_held  = w_evt.shift_held;
    assign o_evt.alt_held    = w_evt.alt_held;
    assign o_evt.capslock_on = w_evt.capslock_on;
    assign o_evt.last_event  = w_evt.last_event;

endmodule

[rtl/hrkd_checker.sv]
// ----------------------------------------------------------------------------
// hrkd_checker
// Port-level checks for the report differencer, bound to the top level.
// ----------------------------------------------------------------------------
module hrkd_checker import hrkd_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_req_op,
    input logic             i_evt_valid,
    input logic             i_evt_ready,
    input logic [KEY_W-1:0] i_evt_key_code
);

    a_evt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid && !i_evt_ready |=> i_evt_valid && $stable(i_evt_key_code))
        else $error("event dropped or changed while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_op == OP_REPORT) |=> !i_req_ready)
        else $error("report request taken while the slot walk is busy");

    a_evt_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_evt_valid) |-> !i_req_ready)
        else $error("new event appeared while idle");

    a_key_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid |-> i_evt_key_code != EMPTY_KEY)
        else $error("event for an empty key slot");

endmodule

bind hid_report_key_event_diff_core hrkd_checker u_hrkd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_op       (i_req.operation),
    .i_evt_valid    (o_evt.valid),
    .i_evt_ready    (o_evt.ready),
    .i_evt_key_code (o_evt.key_code)
);
